/* hdl/brt_pkg.sv */
// ----------------------------------------------------------------------------
// Buffer release tracker package
// Shared constants and codes for the buffer release tracker.
// ----------------------------------------------------------------------------
package brt_pkg;

   localparam int TableEntries = 16;
   localparam int MaxConsumers = 8;
   localparam logic [31:0] TimeoutReset = 32'd1000;

   localparam logic [1:0] REQ_REGISTER   = 2'd0;
   localparam logic [1:0] REQ_RELEASE    = 2'd1;
   localparam logic [1:0] REQ_TICK       = 2'd2;
   localparam logic [1:0] REQ_DISCONNECT = 2'd3;

   localparam logic [2:0] RSP_REGISTERED = 3'd0;
   localparam logic [2:0] RSP_REJECTED   = 3'd1;
   localparam logic [2:0] RSP_PENDING    = 3'd2;
   localparam logic [2:0] RSP_UNKNOWN    = 3'd3;
   localparam logic [2:0] RSP_DUPLICATE  = 3'd4;
   localparam logic [2:0] RSP_RECLAIM    = 3'd5;
   localparam logic [2:0] RSP_DONE       = 3'd6;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_TIMEOUT = 2'd1;
   localparam logic [1:0] ST_DISCONN = 2'd2;

   function automatic logic [3:0] popcount8(input logic [7:0] v);
      logic [3:0] n;
      n = 4'd0;
      for (int i = 0; i < 8; i++) n = n + {3'd0, v[i]};
      return n;
   endfunction

endpackage

/* hdl/buffer_release_tracker_top.sv */
// ----------------------------------------------------------------------------
// Buffer release tracker
// Table of pending frame buffers with per-consumer release tracking and timeout.
// ----------------------------------------------------------------------------
// Usage: requests enter on the req_ stream (one transaction per item), results
// leave on the rsp_ stream; rsp_tlast marks the final result of an item. The
// user must write the timeout register through csr_ only while the block is
// idle; the block itself does not enforce this. The table lives in a
// synchronous memory with one read port, so each item is processed by a
// sequencer that visits the slots one per cycle; a tick or disconnect scan
// pauses while a reclaim waits on a stalled receiver. Register and release
// items search all slots and return one result after the scan; an entry that
// the item changes is written back in state S_OUT, which follows S_FINISH.
// Tick and disconnect items scan every slot, emitting a reclaim for each
// finished entry as its slot is visited, and offer the done result after the
// scan. The next item is accepted only in S_IDLE with no result pending; one
// item is handled at a time.
// Reset clears all valid bits and the timeout register to 1000; the entry
// memories are not cleared. When the receiver stalls, the scan and the input
// wait with the pending result held in the output register.
// ----------------------------------------------------------------------------
module buffer_release_tracker_top #(
   parameter int TABLE_ENTRIES = brt_pkg::TableEntries
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: stream key[31:0], frame number[95:32], buffer key[127:96],
   // consumer index[130:128], consumer mask[138:131], zero fill to 144
   input  logic [143:0] req_tdata,
   // tuser: req_type
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: reclaim_status[1:0], out_stream[33:2], out_frame[97:34],
   // out_buffer[129:98], expected_count[133:130], observed_count[137:134],
   // pending_count[142:138], zero fill to 144
   output logic [143:0] rsp_tdata,
   // tuser: resp_code
   output logic [2:0]   rsp_tuser,
   output logic         rsp_tlast,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [31:0]  csr_data
);
   localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);

   typedef enum logic [2:0] {S_IDLE, S_SCAN, S_WAIT, S_FINISH, S_OUT}
      state_type;
   typedef logic [32+64+32+8+8+32-1:0] entry_type;

   // Entry memory: stream, frame, buffer, expected, released, ticks.
   entry_type mem [TABLE_ENTRIES];
   entry_type rd_ff;
   logic [IW-1:0] raddr;
   logic          rd_en;
   logic          we;
   logic [IW-1:0] waddr;
   entry_type     wdata;
   entry_type     wb_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (rd_en) rd_ff <= mem[raddr];
   end

   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [31:0] tmo_ff;
   state_type state_ff;
   logic [IW:0] idx_ff;     // next address to read
   logic [IW-1:0] cur_ff;   // address whose data is in rd_ff
   logic rdv_ff;
   logic [1:0] typ_ff;
   logic [31:0] s_ff, b_ff;
   logic [63:0] f_ff;
   logic [7:0] cbit_ff, mask_ff;
   logic found_ff;
   logic [IW-1:0] hit_ff;
   entry_type hit_data_ff;
   logic [143:0] od_ff;
   logic [2:0] oc_ff;
   logic ol_ff, ov_ff;

   assign req_tready = (state_ff == S_IDLE) && !ov_ff;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;
   assign rsp_tuser  = oc_ff;
   assign rsp_tlast  = ol_ff;

   // Entry fields of the current read.
   logic [31:0] e_s, e_b, e_t;
   logic [63:0] e_f;
   logic [7:0] e_x, e_r;
   assign {e_s, e_f, e_b, e_x, e_r, e_t} = rd_ff;

   logic [CW-1:0] live;
   always_comb begin
      live = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) live = live + CW'(valid_ff[i]);
   end

   function automatic logic [143:0] pack(input logic [1:0] st, input logic [31:0] s,
         input logic [63:0] f, input logic [31:0] b, input logic [7:0] x,
         input logic [7:0] r, input logic [CW-1:0] p);
      return {1'b0, 5'(p), brt_pkg::popcount8(r), brt_pkg::popcount8(x), b, f, s, st};
   endfunction

   // Scan-step decision for tick and disconnect.
   logic [31:0] t_new;
   logic [7:0] r_new;
   logic recl;
   always_comb begin
      t_new = (e_t != 32'd0) ? e_t - 32'd1 : 32'd0;
      r_new = e_r | (e_x & cbit_ff);
      recl = (typ_ff == brt_pkg::REQ_TICK) ? (t_new == 32'd0) : (r_new == e_x);
   end

   logic stepv;
   assign stepv = rdv_ff && valid_ff[cur_ff];
   logic [IW-1:0] lowfree;
   logic anyfree;
   always_comb begin
      lowfree = '0;
      anyfree = 1'b0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
         if (!valid_ff[i]) begin
            lowfree = IW'(i);
            anyfree = 1'b1;
         end
   end

   logic scan_mode;
   assign scan_mode = typ_ff[1];
   // The scan pauses while a reclaim waits in the output register.
   logic stall;
   assign stall = scan_mode && ov_ff && !rsp_tready;
   logic emit_recl;
   assign emit_recl = (state_ff == S_SCAN) && stepv && scan_mode && !stall && recl;

   assign raddr = idx_ff[IW-1:0];
   // A stalled scan keeps the entry of the current slot in the read register.
   assign rd_en = !stall;

   logic [7:0] hx, hr;
   assign hx = hit_data_ff[47:40];
   assign hr = hit_data_ff[39:32];
   logic [7:0] hr_new;
   assign hr_new = hr | cbit_ff;

   always_comb begin
      we = 1'b0;
      waddr = cur_ff;
      wdata = wb_ff;
      valid_in = valid_ff;
      if (state_ff == S_SCAN && stepv && scan_mode && !stall) begin
         we = 1'b1;
         wdata = (typ_ff == brt_pkg::REQ_TICK) ? {e_s, e_f, e_b, e_x, e_r, t_new}
                                               : {e_s, e_f, e_b, e_x, r_new, e_t};
         if (recl) valid_in[cur_ff] = 1'b0;
      end else if (state_ff == S_OUT) begin
         // Write-back of register and release updates.
         we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         tmo_ff <= brt_pkg::TimeoutReset;
         ov_ff <= 1'b0;
         rdv_ff <= 1'b0;
      end else begin
         if (csr_valid) tmo_ff <= csr_data;
         if (ov_ff && rsp_tready && !emit_recl) ov_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               rdv_ff <= 1'b0;
               if (req_tvalid && req_tready) begin
                  typ_ff  <= req_tuser;
                  s_ff    <= req_tdata[31:0];
                  f_ff    <= req_tdata[95:32];
                  b_ff    <= req_tdata[127:96];
                  cbit_ff <= 8'(9'd1 << req_tdata[130:128]);
                  mask_ff <= req_tdata[138:131];
                  found_ff <= 1'b0;
                  idx_ff <= '0;
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (!stall) begin
                  if (idx_ff < (IW+1)'(TABLE_ENTRIES)) begin
                     idx_ff <= idx_ff + 1'b1;
                     cur_ff <= idx_ff[IW-1:0];
                     rdv_ff <= 1'b1;
                  end else begin
                     rdv_ff <= 1'b0;
                  end
                  if (stepv) begin
                     if (scan_mode) begin
                        if (recl) begin
                           ov_ff <= 1'b1;
                           oc_ff <= brt_pkg::RSP_RECLAIM;
                           ol_ff <= 1'b0;
                           od_ff <= pack((typ_ff == brt_pkg::REQ_TICK) ?
                              brt_pkg::ST_TIMEOUT : brt_pkg::ST_DISCONN, e_s, e_f,
                              e_b, e_x, (typ_ff == brt_pkg::REQ_TICK) ? e_r : r_new,
                              live - 1'b1);
                        end
                     end else if (e_s == s_ff && e_f == f_ff && e_b == b_ff) begin
                        found_ff <= 1'b1;
                        hit_ff <= cur_ff;
                        hit_data_ff <= rd_ff;
                     end
                  end
                  if (!rdv_ff && idx_ff == (IW+1)'(TABLE_ENTRIES))
                     state_ff <= S_WAIT;
               end
            end
            S_WAIT: state_ff <= S_FINISH;
            S_FINISH: begin
               if (!ov_ff) begin
                  ov_ff <= 1'b1;
                  ol_ff <= 1'b1;
                  state_ff <= S_IDLE;
                  case (typ_ff)
                     brt_pkg::REQ_REGISTER: begin
                        if (mask_ff == 8'd0 || found_ff || !anyfree) begin
                           oc_ff <= brt_pkg::RSP_REJECTED;
                           od_ff <= pack(brt_pkg::ST_OK, s_ff, f_ff, b_ff, 8'd0, 8'd0, live);
                        end else begin
                           oc_ff <= brt_pkg::RSP_REGISTERED;
                           valid_ff[lowfree] <= 1'b1;
                           od_ff <= pack(brt_pkg::ST_OK, s_ff, f_ff, b_ff, mask_ff, 8'd0,
                                         live + 1'b1);
                           state_ff <= S_OUT;
                           cur_ff <= lowfree;
                        end
                     end
                     brt_pkg::REQ_RELEASE: begin
                        if (!found_ff) begin
                           oc_ff <= brt_pkg::RSP_UNKNOWN;
                           od_ff <= pack(brt_pkg::ST_OK, s_ff, f_ff, b_ff, 8'd0, 8'd0, live);
                        end else if ((hx & cbit_ff) == 8'd0) begin
                           oc_ff <= brt_pkg::RSP_UNKNOWN;
                           od_ff <= pack(brt_pkg::ST_OK, s_ff, f_ff, b_ff, hx, hr, live);
                        end else if ((hr & cbit_ff) != 8'd0) begin
                           oc_ff <= brt_pkg::RSP_DUPLICATE;
                           od_ff <= pack(brt_pkg::ST_OK, s_ff, f_ff, b_ff, hx, hr, live);
                        end else begin
                           state_ff <= S_OUT;
                           cur_ff <= hit_ff;
                           if (hr_new == hx) begin
                              valid_ff[hit_ff] <= 1'b0;
                              oc_ff <= brt_pkg::RSP_RECLAIM;
                              od_ff <= pack(brt_pkg::ST_OK, s_ff, f_ff, b_ff, hx, hr_new,
                                            live - 1'b1);
                           end else begin
                              oc_ff <= brt_pkg::RSP_PENDING;
                              od_ff <= pack(brt_pkg::ST_OK, s_ff, f_ff, b_ff, hx, hr_new, live);
                           end
                        end
                     end
                     default: begin
                        oc_ff <= brt_pkg::RSP_DONE;
                        od_ff <= pack(brt_pkg::ST_OK, 32'd0, 64'd0, 32'd0, 8'd0, 8'd0, live);
                     end
                  endcase
               end
            end
            S_OUT: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
         if (state_ff == S_SCAN) valid_ff <= valid_in;
      end
   end

   // Write-back data of register and release updates, captured in S_FINISH and written in S_OUT.
   always_ff @(posedge clock) begin
      if (state_ff == S_FINISH)
         wb_ff <= (typ_ff == brt_pkg::REQ_REGISTER) ?
            {s_ff, f_ff, b_ff, mask_ff, 8'd0, tmo_ff} :
            {hit_data_ff[175:40], hr_new, hit_data_ff[31:0]};
   end

`ifndef ASSERT_OFF
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("result dropped");
   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid) else $error("accept with pending result");
   a_count: assert property (@(posedge clock) disable iff (reset)
      live <= CW'(TABLE_ENTRIES)) else $error("count overflow");
`endif
endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buffer release tracker testbench
// Drives register, release, tick and disconnect requests through the request
// stream and checks every result against a cycle-free table predictor.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CycleLimit = 1000000;
   localparam int DrainCycles = 40;

   typedef struct {
      logic [1:0]  kind;
      logic [31:0] stream;
      logic [63:0] frame;
      logic [31:0] buffer;
      logic [2:0]  cid;
      logic [7:0]  mask;
      bit          has_code;
      logic [2:0]  code;
   } req_item_type;

   typedef struct {
      logic [2:0]  code;
      logic [1:0]  status;
      logic [31:0] stream;
      logic [63:0] frame;
      logic [31:0] buffer;
      logic [3:0]  exp_cnt;
      logic [3:0]  obs_cnt;
      logic [4:0]  pending;
      logic        last;
   } rsp_item_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [143:0] req_tdata;
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [143:0] rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         csr_valid;
   logic         csr_ready;
   logic [31:0]  csr_data;

   // Predicted copy of the slot table.
   bit          tbl_valid [brt_pkg::TableEntries];
   logic [31:0] tbl_stream [brt_pkg::TableEntries];
   logic [63:0] tbl_frame [brt_pkg::TableEntries];
   logic [31:0] tbl_buffer [brt_pkg::TableEntries];
   logic [7:0]  tbl_expected [brt_pkg::TableEntries];
   logic [7:0]  tbl_released [brt_pkg::TableEntries];
   logic [31:0] tbl_ticks [brt_pkg::TableEntries];
   logic [31:0] timeout_cfg;

   rsp_item_type expected_rsps[$];
   req_item_type directed_rows[$];
   logic [31:0] pool_stream [8];
   logic [63:0] pool_frame [8];
   logic [31:0] pool_buffer [8];
   int          error_count = 0;
   int          cycle_count = 0;
   bit          idle_en;
   bit          hold_rsp;
   bit          hold_done;

   buffer_release_tracker_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [3:0] ones(input logic [7:0] v);
      logic [3:0] n;
      n = 4'd0;
      for (int i = 0; i < 8; i++) n += {3'd0, v[i]};
      return n;
   endfunction

   function automatic logic [4:0] live_entries();
      logic [4:0] n;
      n = 5'd0;
      for (int i = 0; i < brt_pkg::TableEntries; i++) n += {4'd0, tbl_valid[i]};
      return n;
   endfunction

   function automatic rsp_item_type slot_rsp(input int i, input logic [2:0] code,
                                             input logic [1:0] status, input logic last);
      rsp_item_type r;
      r = '{code, status, tbl_stream[i], tbl_frame[i], tbl_buffer[i],
            ones(tbl_expected[i]), ones(tbl_released[i]), live_entries(), last};
      return r;
   endfunction

   function automatic rsp_item_type key_rsp(input logic [2:0] code, input req_item_type it);
      rsp_item_type r;
      r = '{code, brt_pkg::ST_OK, it.stream, it.frame, it.buffer, 4'd0, 4'd0,
            live_entries(), 1'b1};
      return r;
   endfunction

   function automatic int find_slot(input req_item_type it);
      for (int i = 0; i < brt_pkg::TableEntries; i++)
         if (tbl_valid[i] && tbl_stream[i] == it.stream && tbl_frame[i] == it.frame &&
             tbl_buffer[i] == it.buffer) return i;
      return -1;
   endfunction

   // Updates the predicted table for one accepted transaction and queues its results.
   task automatic predict_results(input req_item_type it);
      rsp_item_type r;
      rsp_item_type batch[$];
      int           slot;
      int           free_slot;
      logic [7:0]   cbit;
      bit           done;
      cbit = 8'd1 << it.cid;
      free_slot = -1;
      for (int i = brt_pkg::TableEntries - 1; i >= 0; i--)
         if (!tbl_valid[i]) free_slot = i;
      slot = find_slot(it);
      case (it.kind)
         brt_pkg::REQ_REGISTER: begin
            if (it.mask == 8'd0 || slot >= 0 || free_slot < 0) begin
               batch = {batch, key_rsp(brt_pkg::RSP_REJECTED, it)};
            end else begin
               tbl_valid[free_slot] = 1'b1;
               tbl_stream[free_slot] = it.stream;
               tbl_frame[free_slot] = it.frame;
               tbl_buffer[free_slot] = it.buffer;
               tbl_expected[free_slot] = it.mask;
               tbl_released[free_slot] = 8'd0;
               tbl_ticks[free_slot] = timeout_cfg;
               batch = {batch, slot_rsp(free_slot, brt_pkg::RSP_REGISTERED,
                                        brt_pkg::ST_OK, 1'b1)};
            end
         end
         brt_pkg::REQ_RELEASE: begin
            if (slot < 0) begin
               batch = {batch, key_rsp(brt_pkg::RSP_UNKNOWN, it)};
            end else if ((tbl_expected[slot] & cbit) == 8'd0) begin
               batch = {batch, slot_rsp(slot, brt_pkg::RSP_UNKNOWN, brt_pkg::ST_OK, 1'b1)};
            end else if ((tbl_released[slot] & cbit) != 8'd0) begin
               batch = {batch, slot_rsp(slot, brt_pkg::RSP_DUPLICATE, brt_pkg::ST_OK, 1'b1)};
            end else begin
               tbl_released[slot] |= cbit;
               if (tbl_released[slot] == tbl_expected[slot]) begin
                  tbl_valid[slot] = 1'b0;
                  batch = {batch, slot_rsp(slot, brt_pkg::RSP_RECLAIM, brt_pkg::ST_OK, 1'b1)};
               end else begin
                  batch = {batch, slot_rsp(slot, brt_pkg::RSP_PENDING, brt_pkg::ST_OK, 1'b1)};
               end
            end
         end
         default: begin
            for (int i = 0; i < brt_pkg::TableEntries; i++) begin
               if (tbl_valid[i]) begin
                  if (it.kind == brt_pkg::REQ_TICK) begin
                     if (tbl_ticks[i] != 32'd0) tbl_ticks[i]--;
                     done = (tbl_ticks[i] == 32'd0);
                  end else begin
                     tbl_released[i] |= tbl_expected[i] & cbit;
                     done = (tbl_released[i] == tbl_expected[i]);
                  end
                  if (done) begin
                     tbl_valid[i] = 1'b0;
                     batch = {batch, slot_rsp(i, brt_pkg::RSP_RECLAIM,
                                              (it.kind == brt_pkg::REQ_TICK) ?
                                              brt_pkg::ST_TIMEOUT : brt_pkg::ST_DISCONN,
                                              1'b0)};
                  end
               end
            end
            r = '{brt_pkg::RSP_DONE, brt_pkg::ST_OK, 32'd0, 64'd0, 32'd0, 4'd0, 4'd0,
                  live_entries(), 1'b1};
            batch = {batch, r};
         end
      endcase
      // A typed-in code for a directed row takes the place of the predicted code of its first result.
      if (it.has_code) batch[0].code = it.code;
      expected_rsps = {expected_rsps, batch};
   endtask

   task automatic send_item(input req_item_type it);
      if (idle_en && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= it.kind;
      req_tdata <= {5'd0, it.mask, it.cid, it.buffer, it.frame, it.stream};
      do @(posedge clock); while (!req_tready);
      predict_results(it);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_timeout(input logic [31:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      timeout_cfg = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic req_item_type make_row(input logic [1:0] kind, input logic [31:0] s,
                                             input logic [63:0] f, input logic [31:0] b,
                                             input logic [2:0] cid, input logic [7:0] mask,
                                             input bit has_code, input logic [2:0] code);
      req_item_type it;
      it = '{kind, s, f, b, cid, mask, has_code, code};
      return it;
   endfunction

   task automatic add_row(input req_item_type it);
      directed_rows = {directed_rows, it};
   endtask

   // Mostly well-formed traffic: registers from a small key pool so duplicates
   // occur, releases aimed at live entries with an expected consumer.
   function automatic req_item_type random_item();
      req_item_type it;
      int           p;
      int           live[$];
      int           pick;
      p = $urandom_range(0, 7);
      it = make_row(brt_pkg::REQ_REGISTER, $urandom, {$urandom, $urandom}, $urandom,
                    3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), 1'b0,
                    brt_pkg::RSP_REGISTERED);
      if ($urandom_range(0, 1) == 1) begin
         it.stream = pool_stream[p];
         it.frame = pool_frame[p];
         it.buffer = pool_buffer[p];
      end
      if ($urandom_range(0, 15) == 0) it.mask = 8'd0;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         it.kind = brt_pkg::REQ_REGISTER;
      end else if (pick < 78) begin
         it.kind = brt_pkg::REQ_RELEASE;
         for (int i = 0; i < brt_pkg::TableEntries; i++) if (tbl_valid[i]) live = {live, i};
         if (live.size() > 0 && $urandom_range(0, 5) != 0) begin
            p = live[$urandom_range(0, live.size() - 1)];
            it.stream = tbl_stream[p];
            it.frame = tbl_frame[p];
            it.buffer = tbl_buffer[p];
            if ($urandom_range(0, 3) != 0)
               for (int k = 0; k < 8; k++) begin
                  it.cid = 3'($urandom_range(0, 7));
                  if (tbl_expected[p][it.cid]) break;
               end
         end
      end else if (pick < 92) begin
         it.kind = brt_pkg::REQ_TICK;
      end else begin
         it.kind = brt_pkg::REQ_DISCONNECT;
      end
      return it;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Result checker.
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected result transaction, code %0d", rsp_tuser);
            error_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_tuser !== want.code) begin
               $error("resp_code expected %0d actual %0d", want.code, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata[1:0] !== want.status) begin
               $error("reclaim_status expected %0d actual %0d", want.status, rsp_tdata[1:0]);
               error_count++;
            end
            if (rsp_tdata[33:2] !== want.stream) begin
               $error("out_stream expected %h actual %h", want.stream, rsp_tdata[33:2]);
               error_count++;
            end
            if (rsp_tdata[97:34] !== want.frame) begin
               $error("out_frame expected %h actual %h", want.frame, rsp_tdata[97:34]);
               error_count++;
            end
            if (rsp_tdata[129:98] !== want.buffer) begin
               $error("out_buffer expected %h actual %h", want.buffer, rsp_tdata[129:98]);
               error_count++;
            end
            if (rsp_tdata[133:130] !== want.exp_cnt) begin
               $error("expected_count expected %0d actual %0d", want.exp_cnt,
                      rsp_tdata[133:130]);
               error_count++;
            end
            if (rsp_tdata[137:134] !== want.obs_cnt) begin
               $error("observed_count expected %0d actual %0d", want.obs_cnt,
                      rsp_tdata[137:134]);
               error_count++;
            end
            if (rsp_tdata[142:138] !== want.pending) begin
               $error("pending_count expected %0d actual %0d", want.pending,
                      rsp_tdata[142:138]);
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last expected %0d actual %0d", want.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin
      rsp_tready = 1'b0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (300) @(negedge clock);
            hold_done = 1'b1;
            rsp_tready <= 1'b1;
         end else if (!idle_en || $urandom_range(0, 3) != 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 9) - 1) @(negedge clock);
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = brt_pkg::REQ_REGISTER;
      csr_valid = 1'b0;
      csr_data = '0;
      hold_rsp = 1'b0;
      idle_en = 1'b1;
      timeout_cfg = brt_pkg::TimeoutReset;
      for (int i = 0; i < brt_pkg::TableEntries; i++) tbl_valid[i] = 1'b0;
      for (int i = 0; i < 8; i++) begin
         pool_stream[i] = $urandom;
         pool_frame[i] = {$urandom, $urandom};
         pool_buffer[i] = $urandom;
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      add_row(make_row(brt_pkg::REQ_TICK, 32'd0, 64'd0, 32'd0, 3'd0, 8'h00,
                       1'b1, brt_pkg::RSP_DONE));
      add_row(make_row(brt_pkg::REQ_REGISTER, 32'd1, 64'd1, 32'd1, 3'd0, 8'h00,
                       1'b1, brt_pkg::RSP_REJECTED));
      add_row(make_row(brt_pkg::REQ_REGISTER, '1, '1, '1, 3'd7, 8'hFF,
                       1'b1, brt_pkg::RSP_REGISTERED));
      add_row(make_row(brt_pkg::REQ_REGISTER, '1, '1, '1, 3'd0, 8'h01,
                       1'b1, brt_pkg::RSP_REJECTED));
      add_row(make_row(brt_pkg::REQ_REGISTER, 32'd0, 64'd0, 32'd0, 3'd0, 8'h01,
                       1'b1, brt_pkg::RSP_REGISTERED));
      add_row(make_row(brt_pkg::REQ_RELEASE, 32'd5, 64'd5, 32'd5, 3'd0, 8'h00,
                       1'b1, brt_pkg::RSP_UNKNOWN));
      add_row(make_row(brt_pkg::REQ_RELEASE, 32'd0, 64'd0, 32'd0, 3'd3, 8'h00,
                       1'b1, brt_pkg::RSP_UNKNOWN));
      add_row(make_row(brt_pkg::REQ_RELEASE, 32'd0, 64'd0, 32'd0, 3'd0, 8'h00,
                       1'b1, brt_pkg::RSP_RECLAIM));
      add_row(make_row(brt_pkg::REQ_RELEASE, '1, '1, '1, 3'd7, 8'h00,
                       1'b1, brt_pkg::RSP_PENDING));
      add_row(make_row(brt_pkg::REQ_RELEASE, '1, '1, '1, 3'd7, 8'h00,
                       1'b1, brt_pkg::RSP_DUPLICATE));
      add_row(make_row(brt_pkg::REQ_REGISTER, 32'hA5A5_5A5A, 64'h0123_4567_89AB_CDEF,
                       32'h5A5A_A5A5, 3'd0, 8'h81, 1'b0, brt_pkg::RSP_REGISTERED));
      add_row(make_row(brt_pkg::REQ_DISCONNECT, 32'd0, 64'd0, 32'd0, 3'd7, 8'h00,
                       1'b0, brt_pkg::RSP_DONE));
      for (int c = 0; c < 7; c++)
         add_row(make_row(brt_pkg::REQ_DISCONNECT, 32'd0, 64'd0, 32'd0, 3'(c), 8'h00,
                          1'b0, brt_pkg::RSP_DONE));
      foreach (directed_rows[i]) send_item(directed_rows[i]);

      // Zero timeout: fill the table, one more register overflows, one tick clears all.
      write_timeout(32'd0);
      for (int i = 0; i < brt_pkg::TableEntries + 1; i++)
         send_item(make_row(brt_pkg::REQ_REGISTER, 32'(i), {$urandom, $urandom}, $urandom,
                            3'd0, 8'(i + 1), 1'b0, brt_pkg::RSP_REGISTERED));
      send_item(make_row(brt_pkg::REQ_TICK, 32'd0, 64'd0, 32'd0, 3'd0, 8'h00,
                         1'b0, brt_pkg::RSP_DONE));

      write_timeout(32'hFFFF_FFFF);
      for (int n = 0; n < 120; n++) begin
         if (n == 60) hold_rsp = 1'b1;
         send_item(random_item());
      end

      // Sender pause until the table's results are all out.
      write_timeout(32'd5);
      for (int n = 0; n < 120; n++) send_item(random_item());

      write_timeout(32'd1);
      idle_en = 1'b0;
      for (int n = 0; n < 100; n++) send_item(random_item());

      wait_idle();
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
